>>> rtl/h64mix_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the 64-bit multiply-mix key hash.
// Used by the front, back, multiplier and top-level modules.

package h64mix_pkg;

   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_SHIFT = 47;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned BYTES_W = 4;
   localparam int unsigned LEN_W   = 31;
   localparam int unsigned SEED_W  = 32;

   localparam logic [BYTES_W-1:0] FULL_BYTES = 4'd8;

   typedef enum logic [1:0] {
      KIND_FULL,
      KIND_PART,
      KIND_EMPTY
   } word_kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      word_kind_type     kind;
      logic              last;
      logic [LEN_W-1:0]  length;
   } work_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_DISPATCH,
      ST_PM1,
      ST_PM2,
      ST_HMUL,
      ST_AV0,
      ST_AV1,
      ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

>>> rtl/h64mix_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Small register queue between the front and back parts.
// Generic in width and depth; no package dependency.

module h64mix_fifo #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [Width-1:0] push_data,
   input  wire logic             pop,
   output logic      [Width-1:0] head_data,
   output logic                  full,
   output logic                  empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/h64mix_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front part: accepts key words and classifies them as full, partial or empty.
// Depends on h64mix_pkg for the work item layout.

module h64mix_front (
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [63:0]                  req_key_word,
   input  wire logic [3:0]                   req_word_bytes,
   input  wire logic                         req_last_word,
   input  wire logic [30:0]                  req_total_length,
   input  wire logic                         queue_full,
   output logic                              queue_push,
   output h64mix_pkg::work_item_type         queue_item
);
   import h64mix_pkg::*;

   logic [BYTES_W-1:0] nbytes;
   logic [WORD_W-1:0]  masked;

   assign nbytes = (req_word_bytes > FULL_BYTES) ? FULL_BYTES : req_word_bytes;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked[i*8 +: 8] = (BYTES_W'(i) < nbytes) ? req_key_word[i*8 +: 8] : 8'h00;
      end
   end

   always_comb begin
      queue_item.word   = masked;
      queue_item.length = req_total_length;
      if (nbytes == FULL_BYTES) begin
         queue_item.kind = KIND_FULL;
      end else if (nbytes == '0) begin
         queue_item.kind = KIND_EMPTY;
      end else begin
         queue_item.kind = KIND_PART;
      end
      queue_item.last = req_last_word || (nbytes != FULL_BYTES);
   end

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

endmodule

`default_nettype wire

>>> rtl/h64mix_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequential 64-bit by constant multiplier, low 64 bits of the product.
// One 32x32 partial product per cycle; depends on h64mix_pkg for the constant.

module h64mix_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] operand,
   output logic             done,
   output logic [63:0]      product
);
   import h64mix_pkg::*;

   localparam logic [1:0] STEP_LOW  = 2'd0;
   localparam logic [1:0] STEP_MIDA = 2'd1;
   localparam logic [1:0] STEP_MIDB = 2'd2;

   logic [63:0] a_ff;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;

   assign mul_x = (step_ff == STEP_MIDB) ? a_ff[63:32] : a_ff[31:0];
   assign mul_y = (step_ff == STEP_MIDA) ? MIX_MUL[63:32] : MIX_MUL[31:0];
   assign mul_p = 64'(mul_x) * 64'(mul_y);

   always_comb begin
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_LOW;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_LOW: begin
               acc_in  = mul_p;
               step_in = STEP_MIDA;
            end
            STEP_MIDA: begin
               acc_in[63:32] = acc_ff[63:32] + mul_p[31:0];
               step_in       = STEP_MIDB;
            end
            STEP_MIDB: begin
               acc_in[63:32] = acc_ff[63:32] + mul_p[31:0];
               busy_in       = 1'b0;
               done_in       = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LOW;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= operand;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

>>> rtl/h64mix_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back part: sequencer that folds queued words into the running hash,
// holds the seed register and the result register. Uses h64mix_pkg and h64mix_mul.

module h64mix_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [31:0]                  csr_hash_seed,
   input  wire logic                         queue_empty,
   input  h64mix_pkg::work_item_type         queue_head,
   output logic                              queue_pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [63:0]                       rsp_hash_value
);
   import h64mix_pkg::*;

   back_state_type state_ff, state_in;
   work_item_type  cur_ff, cur_in;
   logic [63:0]    hash_ff, hash_in;
   logic           at_start_ff, at_start_in;
   logic [31:0]    seed_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_hash_ff, rsp_hash_in;
   logic           mul_start, mul_done;
   logic [63:0]    mul_a, mul_p;
   logic           out_free;

   h64mix_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_a),
      .done    (mul_done),
      .product (mul_p)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = at_start_ff ? ST_INIT : ST_DISPATCH;
            end
         end
         ST_INIT: begin
            if (mul_done) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (cur_ff.kind)
               KIND_FULL: state_in = ST_PM1;
               KIND_PART: state_in = ST_HMUL;
               default:   state_in = ST_AV0;
            endcase
         end
         ST_PM1: begin
            if (mul_done) begin
               state_in = ST_PM2;
            end
         end
         ST_PM2: begin
            if (mul_done) begin
               state_in = ST_HMUL;
            end
         end
         ST_HMUL: begin
            if (mul_done) begin
               state_in = cur_ff.last ? ST_AV0 : ST_IDLE;
            end
         end
         ST_AV0: begin
            state_in = ST_AV1;
         end
         ST_AV1: begin
            if (mul_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      hash_in      = hash_ff;
      at_start_in  = at_start_ff;
      queue_pop    = 1'b0;
      mul_start    = 1'b0;
      mul_a        = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               cur_in    = queue_head;
               if (at_start_ff) begin
                  mul_start = 1'b1;
                  mul_a     = 64'(queue_head.length);
               end
            end
         end
         ST_INIT: begin
            if (mul_done) begin
               hash_in = 64'(seed_ff) ^ mul_p;
            end
         end
         ST_DISPATCH: begin
            case (cur_ff.kind)
               KIND_FULL: begin
                  mul_start = 1'b1;
                  mul_a     = cur_ff.word;
               end
               KIND_PART: begin
                  mul_start = 1'b1;
                  mul_a     = hash_ff ^ cur_ff.word;
               end
               default: begin
               end
            endcase
         end
         ST_PM1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_p ^ (mul_p >> MIX_SHIFT);
            end
         end
         ST_PM2: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = hash_ff ^ mul_p;
            end
         end
         ST_HMUL: begin
            if (mul_done) begin
               hash_in     = mul_p;
               at_start_in = 1'b0;
            end
         end
         ST_AV0: begin
            mul_start = 1'b1;
            mul_a     = hash_ff ^ (hash_ff >> MIX_SHIFT);
         end
         ST_AV1: begin
            if (mul_done) begin
               hash_in = mul_p ^ (mul_p >> MIX_SHIFT);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_ff;
               hash_in      = '0;
               at_start_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         at_start_ff  <= 1'b1;
         hash_ff      <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         at_start_ff  <= at_start_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            seed_ff <= csr_hash_seed;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire

>>> rtl/hash64_multiply_mix_64bit_words_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the 64-bit multiply-mix key hash.
// Instantiates h64mix_front, h64mix_fifo and h64mix_back; uses h64mix_pkg.
//
//   Port group   Direction  Handshake          Payload
//   req_*        in         valid / stall      key_word, word_bytes, last_word, total_length
//   rsp_*        out        valid / stall      hash_value
//   csr_*        in         valid / ready      hash_seed
//
// Each 64-bit constant multiply runs on one shared 32x32 multiplier.
// A full word takes three multiplies, a partial word one, an empty last word none; the first
// word of a key adds one, and the last word one for the final avalanche and result load.
// Reset is synchronous; the seed clears to zero and the next word starts a key.
// The input queue keeps taking words, until it is full, while the back part or a stalled result waits.

module hash64_multiply_mix_64bit_words_top #(
   parameter int unsigned QueueDepth = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_key_word,
   input  wire logic [3:0]  req_word_bytes,
   input  wire logic        req_last_word,
   input  wire logic [30:0] req_total_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_hash_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_hash_seed
);
   import h64mix_pkg::*;

   work_item_type push_item, head_item;
   logic          q_push, q_pop, q_full, q_empty;

   h64mix_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_word     (req_key_word),
      .req_word_bytes   (req_word_bytes),
      .req_last_word    (req_last_word),
      .req_total_length (req_total_length),
      .queue_full       (q_full),
      .queue_push       (q_push),
      .queue_item       (push_item)
   );

   h64mix_fifo #(
      .Width ($bits(work_item_type)),
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_item),
      .pop       (q_pop),
      .head_data (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   h64mix_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_hash_seed  (csr_hash_seed),
      .queue_empty    (q_empty),
      .queue_head     (head_item),
      .queue_pop      (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire

>>> tb/tb_hash64_multiply_mix_64bit_words_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for hash64_multiply_mix_64bit_words_top: a directed table, then
// random keys under varied seeds, idling and a long result hold-off; each hash is held to a
// built-in 64-bit multiply-mix predictor or a typed row hash. Needs h64mix_pkg and RTL top.

module tb_hash64_multiply_mix_64bit_words_top;
   import h64mix_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_REPORTS   = 10;
   localparam int DIR_ROWS      = 22;

   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  nbytes;
      logic        last;
      logic [30:0] len;
   } key_xfer_type;

   typedef struct packed {
      key_xfer_type xfer;
      logic         typed;
      logic [63:0]  typed_hash;
   } dir_row_type;

   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{'{64'h0,                   4'd0,  1'b1, 31'd0},          1'b1, 64'h0},
      '{'{ONES,                    4'd0,  1'b0, 31'd0},          1'b1, 64'h0},
      '{'{64'hFFFF_FFFF_FFFF_FF00, 4'd1,  1'b1, 31'd0},          1'b1, 64'h0},
      '{'{64'hFF00_0000_0000_0000, 4'd7,  1'b0, 31'd0},          1'b1, 64'h0},
      '{'{64'h0,                   4'd8,  1'b1, 31'd8},          1'b0, 64'h0},
      '{'{ONES,                    4'd8,  1'b1, 31'd8},          1'b0, 64'h0},
      '{'{64'h0123_4567_89AB_CDEF, 4'd8,  1'b0, 31'd19},         1'b0, 64'h0},
      '{'{64'hFEDC_BA98_7654_3210, 4'd8,  1'b0, 31'd19},         1'b0, 64'h0},
      '{'{64'h0000_0000_00AA_BBCC, 4'd3,  1'b1, 31'd19},         1'b0, 64'h0},
      '{'{64'h8000_0000_0000_0001, 4'd15, 1'b1, 31'h7FFF_FFFF},  1'b0, 64'h0},
      '{'{ONES,                    4'd9,  1'b0, 31'h7FFF_FFFF},  1'b0, 64'h0},
      '{'{64'h5555_5555_5555_5555, 4'd8,  1'b0, 31'd0},          1'b0, 64'h0},
      '{'{64'h0,                   4'd0,  1'b1, 31'd0},          1'b0, 64'h0},
      '{'{64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  1'b0, 31'd16},         1'b0, 64'h0},
      '{'{64'h1234_5678_9ABC_DEF0, 4'd0,  1'b0, 31'd0},          1'b0, 64'h0},
      '{'{ONES,                    4'd2,  1'b1, 31'd100},        1'b0, 64'h0},
      '{'{ONES,                    4'd4,  1'b1, 31'd4},          1'b0, 64'h0},
      '{'{ONES,                    4'd5,  1'b0, 31'd5},          1'b0, 64'h0},
      '{'{ONES,                    4'd6,  1'b1, 31'd6},          1'b0, 64'h0},
      '{'{64'h7FFF_FFFF_FFFF_FFFF, 4'd12, 1'b0, 31'h4000_0000},  1'b0, 64'h0},
      '{'{64'hDEAD_BEEF_CAFE_F00D, 4'd7,  1'b1, 31'd15},         1'b0, 64'h0},
      '{'{64'h0,                   4'd0,  1'b1, 31'h7FFF_FFFF},  1'b0, 64'h0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_key_word;
   logic [3:0]  req_word_bytes;
   logic        req_last_word;
   logic [30:0] req_total_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_hash_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_hash_seed;

   logic [63:0] run_hash;
   logic        key_open;
   logic [31:0] seed_copy;
   logic [63:0] pending_hashes [$];

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_trigger;
   int mismatch_count;
   int cycle_count;

   hash64_multiply_mix_64bit_words_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_word     (req_key_word),
      .req_word_bytes   (req_word_bytes),
      .req_last_word    (req_last_word),
      .req_total_length (req_total_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_hash_seed    (csr_hash_seed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** hash64_multiply_mix_64bit_words_top: FAILED **");
         $finish;
      end
   end

   function automatic bit fold_key_word(input key_xfer_type w, output logic [63:0] hash_out);
      logic [63:0] h;
      logic [63:0] k;
      logic [63:0] mask;
      logic [3:0]  nb;
      logic        ends;
      nb = (w.nbytes > FULL_BYTES) ? FULL_BYTES : w.nbytes;
      ends = w.last;
      h = key_open ? run_hash : ({32'd0, seed_copy} ^ ({33'd0, w.len} * MIX_MUL));
      if (nb == FULL_BYTES) begin
         k = w.key * MIX_MUL;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MUL;
         h = (h ^ k) * MIX_MUL;
      end else begin
         if (nb != 4'd0) begin
            mask = '0;
            for (int i = 0; i < 8; i++)
               if (i < nb) mask[8*i +: 8] = 8'hFF;
            h = (h ^ (w.key & mask)) * MIX_MUL;
         end
         ends = 1'b1;
      end
      hash_out = '0;
      if (ends) begin
         h = h ^ (h >> MIX_SHIFT);
         h = h * MIX_MUL;
         hash_out = h ^ (h >> MIX_SHIFT);
         run_hash = '0;
         key_open = 1'b0;
      end else begin
         run_hash = h;
         key_open = 1'b1;
      end
      return ends;
   endfunction

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_trigger = 1'b0;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hashes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected hash transfer %h", $realtime, rsp_hash_value);
         end else begin
            want = pending_hashes.pop_front();
            if (rsp_hash_value !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: hash_value expected %h actual %h",
                           $realtime, want, rsp_hash_value);
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_word(input key_xfer_type w, input logic typed,
                            input logic [63:0] typed_hash);
      logic [63:0] predicted;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_key_word     = w.key;
      req_word_bytes   = w.nbytes;
      req_last_word    = w.last;
      req_total_length = w.len;
      do @(posedge clock); while (req_stall);
      if (fold_key_word(w, predicted))
         pending_hashes.push_back(typed ? typed_hash : predicted);
      @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      @(negedge clock);
      csr_valid     = 1'b1;
      csr_hash_seed = value;
      do @(posedge clock); while (!csr_ready);
      seed_copy = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_key(inout int sent);
      key_xfer_type w;
      int           nfull;
      int           tail;
      bit           end_on_full;
      logic [30:0]  len;
      if ($urandom_range(99) < 8) begin
         w.key    = {$urandom, $urandom};
         w.nbytes = 4'($urandom_range(15));
         w.last   = 1'($urandom_range(1));
         w.len    = 31'($urandom);
         send_word(w, 1'b0, '0);
         sent++;
      end else begin
         nfull       = ($urandom_range(99) < 5) ? $urandom_range(8, 24) : $urandom_range(0, 4);
         tail        = $urandom_range(0, 7);
         end_on_full = 1'($urandom_range(1));
         len         = 31'(nfull * 8 + tail);
         if ($urandom_range(99) < 10) len = 31'($urandom);
         for (int i = 0; i < nfull; i++) begin
            w.key    = {$urandom, $urandom};
            w.nbytes = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : FULL_BYTES;
            w.last   = (i == nfull - 1) && (tail == 0) && end_on_full;
            w.len    = len;
            send_word(w, 1'b0, '0);
            sent++;
         end
         if (!(nfull > 0 && tail == 0 && end_on_full)) begin
            w.key    = {$urandom, $urandom};
            w.nbytes = 4'(tail);
            w.last   = ($urandom_range(3) != 0);
            w.len    = len;
            send_word(w, 1'b0, '0);
            sent++;
         end
      end
   endtask

   task automatic run_phase(input logic [31:0] seed, input int s_pct, input int r_pct,
                            input bit squeeze, input int target);
      int           sent;
      key_xfer_type stop_word;
      sent = 0;
      write_seed(seed);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      if (squeeze) hold_trigger = 1'b1;
      while (sent < target) send_random_key(sent);
      if (key_open) begin
         stop_word = '{{$urandom, $urandom}, 4'd0, 1'b1, 31'($urandom)};
         send_word(stop_word, 1'b0, '0);
      end
      req_valid = 1'b0;
      wait_drained();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_key_word     = '0;
      req_word_bytes   = '0;
      req_last_word    = 1'b0;
      req_total_length = '0;
      csr_valid        = 1'b0;
      csr_hash_seed    = '0;
      run_hash         = '0;
      key_open         = 1'b0;
      seed_copy        = '0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_trigger     = 1'b0;
      mismatch_count   = 0;
      cycle_count      = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_word(DIRECTED[i].xfer, DIRECTED[i].typed, DIRECTED[i].typed_hash);
      req_valid = 1'b0;
      wait_drained();

      run_phase(32'hFFFF_FFFF, 27, 49, 1'b0, 600);
      run_phase($urandom,      49, 27, 1'b0, 600);
      run_phase(32'h0000_0001,  0,  0, 1'b0, 400);
      run_phase(32'h0000_0000,  0,  0, 1'b1, 250);

      if (mismatch_count == 0 && pending_hashes.size() == 0) begin
         $display("** hash64_multiply_mix_64bit_words_top: PASSED **");
      end else begin
         $display("** hash64_multiply_mix_64bit_words_top: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/h64mix_pkg.sv
rtl/h64mix_fifo.sv
rtl/h64mix_front.sv
rtl/h64mix_mul.sv
rtl/h64mix_back.sv
rtl/hash64_multiply_mix_64bit_words_top.sv
tb/tb_hash64_multiply_mix_64bit_words_top.sv
